@@ hw/rtl/swm_pkg.sv @@
// shared types and constants for the sliding window median filter
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  // sample width is fixed by the stream format
  localparam int SAMPLE_W   = 16;
  localparam int WINDOW_DEF = 17;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // what a cell shows its neighbors every cycle
  typedef struct packed {
    sample_t value;   // stored sorted entry
    logic    lt_new;  // entry is below the incoming sample
    logic    ge_old;  // entry is at or above the leaving sample
  } link_t;

endpackage

`default_nettype wire

@@ hw/rtl/swm_cell.sv @@
// one cell of the sorted window: a sorted entry plus one history tap
`timescale 1ns / 1ps
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     en,          // a sample word is accepted this cycle
  input  sample_t new_sample,  // broadcast incoming sample
  input  sample_t old_sample,  // broadcast sample leaving the window
  input  wire     old_below,   // leaving sample is below the incoming one
  input  link_t   left,        // neighbor at the next lower index
  input  link_t   right,       // neighbor at the next higher index
  input  sample_t hist_in,     // history line from the previous cell
  output link_t   self,
  output sample_t hist,        // history line to the next cell
  output sample_t value_next
);

  sample_t value;

  // local compares against the two broadcast samples
  assign self.value  = value;
  assign self.lt_new = (value < new_sample);
  assign self.ge_old = (value >= old_sample);

  // pick the new entry from self, a neighbor or the incoming sample
  always_comb begin
    if (old_below) begin
      // removal below the insertion point: entries between shift down
      if (!self.ge_old) begin
        value_next = value;
      end else if (right.lt_new) begin
        value_next = right.value;
      end else if (self.lt_new) begin
        value_next = new_sample;
      end else begin
        value_next = value;
      end
    end else begin
      // insertion at or below the removal point: entries between shift up
      if (self.lt_new) begin
        value_next = value;
      end else if (left.lt_new) begin
        value_next = new_sample;
      end else if (!left.ge_old) begin
        value_next = left.value;
      end else begin
        value_next = value;
      end
    end
  end

  // sorted entry and history tap
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      hist  <= '0;
    end else if (en) begin
      value <= value_next;
      hist  <= hist_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sliding_window_median_top.sv @@
// sliding window median filter: row of sorting cells and output register
//
// Usage: signed 16-bit samples enter on the s_axis channel, one per word.
// For every accepted sample one median word leaves on the m_axis channel:
// the middle entry of the last WINDOW samples in ascending order.
// The median of a sample accepted at a clock edge is registered at that edge
// and offered on m_axis in the cycle after.
// Throughput is one sample per cycle while the receiver does not stall.
// All cells of the row compare their entry with the incoming and the
// leaving sample and update in the same cycle; the leaving sample comes
// from a history line threaded through the cells.
// Reset fills the window with zeros, as if WINDOW zero samples had been
// taken, and empties the output register.
// When the receiver stalls, the median word waits in the output register
// and s_axis_tready stays low until it is taken; a new sample is taken in
// the same cycle as the waiting word leaves.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata    // [15:0] median
);

  localparam int MID = WINDOW / 2;

  logic    accept;
  sample_t new_sample;
  sample_t old_sample;
  logic    old_below;
  link_t   links [WINDOW];
  sample_t hists [WINDOW];
  sample_t nexts [WINDOW];
  sample_t median;

  // input handshake: free output slot or one leaving now
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign new_sample    = sample_t'(s_axis_tdata);

  // sample leaving the window sits at the end of the history line
  assign old_sample = hists[WINDOW-1];
  assign old_below  = (old_sample < new_sample);

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    link_t   left_link;
    link_t   right_link;
    sample_t hist_in;

    if (i == 0) begin : g_first
      assign left_link = '{value: links[i].value, lt_new: 1'b1, ge_old: 1'b1};
      assign hist_in   = new_sample;
    end else begin : g_inner
      assign left_link = links[i-1];
      assign hist_in   = hists[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_link = '{value: links[i].value, lt_new: 1'b0, ge_old: 1'b1};
    end else begin : g_body
      assign right_link = links[i+1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (accept),
      .new_sample (new_sample),
      .old_sample (old_sample),
      .old_below  (old_below),
      .left       (left_link),
      .right      (right_link),
      .hist_in    (hist_in),
      .self       (links[i]),
      .hist       (hists[i]),
      .value_next (nexts[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median <= nexts[MID];
    end
  end

  assign m_axis_tdata = median;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  // every accepted sample leaves a median word behind
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted sample produced no median word");

  // the cell row stays in ascending order
  for (genvar k = 0; k < WINDOW - 1; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      links[k].value <= links[k+1].value)
      else $error("window entries out of order");
  end

endmodule

`default_nettype wire

@@ tb/tb_sliding_window_median_top.sv @@
// testbench for the sliding window median filter: random stream against a sorted-window predictor
`timescale 1ns / 1ps

module tb_sliding_window_median_top;
  import swm_pkg::*;

  localparam int WIN = WINDOW_DEF;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata;   // [15:0] sample
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SAMPLE_W-1:0] m_axis_tdata;   // [15:0] median

  sliding_window_median_top #(.WINDOW(WIN)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // sorted window copy and its age tags
  sample_t sorted_win [WIN];
  int      win_age [WIN];
  sample_t expected_medians [$];
  int      fail_count = 0;

  // sender burst state
  int burst_left = 0;
  // receiver stall pattern state
  int rx_left = 0;
  logic rx_level = 1'b1;
  // ramp generator state for random runs
  sample_t ramp_val = '0;

  task automatic clear_window();
    for (int i = 0; i < WIN; i++) begin
      sorted_win[i] = '0;
      win_age[i] = i;
    end
  endtask

  // drop the oldest entry, age the rest, insert the new sample in order
  function automatic sample_t window_insert(sample_t x);
    int drop;
    int pos;
    drop = WIN - 1;
    for (int i = 0; i < WIN; i++) begin
      if (win_age[i] == 0) begin
        drop = i;
        break;
      end
    end
    for (int i = drop; i < WIN - 1; i++) begin
      sorted_win[i] = sorted_win[i + 1];
      win_age[i] = win_age[i + 1];
    end
    for (int i = 0; i < WIN - 1; i++) begin
      if (win_age[i] > 0) win_age[i] = win_age[i] - 1;
    end
    // below the lowest goes first; otherwise before the first entry after the lowest that is at or above it
    if (x < sorted_win[0]) begin
      pos = 0;
    end else begin
      pos = WIN - 1;
      for (int i = 1; i < WIN - 1; i++) begin
        if (sorted_win[i] >= x) begin
          pos = i;
          break;
        end
      end
    end
    for (int i = WIN - 1; i > pos; i--) begin
      sorted_win[i] = sorted_win[i - 1];
      win_age[i] = win_age[i - 1];
    end
    sorted_win[pos] = x;
    win_age[pos] = WIN - 1;
    return sorted_win[WIN / 2];
  endfunction

  task automatic report_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // result check first, then prediction for the word accepted at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_medians.size() == 0) begin
          report_fail($sformatf("unexpected median word %0d", $signed(m_axis_tdata)));
        end else begin
          sample_t want;
          want = expected_medians.pop_front();
          if (sample_t'(m_axis_tdata) !== want)
            report_fail($sformatf("median mismatch: expected %0d, got %0d",
                                  want, $signed(m_axis_tdata)));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_medians = {expected_medians, window_insert(sample_t'(s_axis_tdata))};
    end
  end

  // receiver: alternating ready and stall stretches of random length
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_level = ($urandom_range(0, 3) != 0);
      rx_left = rx_level ? $urandom_range(1, 24) : $urandom_range(1, 6);
    end else begin
      rx_left--;
    end
    m_axis_tready = rx_level;
  end

  // send one sample word, with bursts and random gaps between them
  task automatic send_sample(sample_t x);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = x;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending until every expected median has arrived
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_medians.size() != 0) @(negedge clk);
  endtask

  // extreme values and alternating bit patterns
  task automatic test_extremes();
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(sample_t'(16'haaaa));
  endtask

  // equal values, including ones equal to entries already in the window
  task automatic test_ties();
    repeat (3) send_sample(16'sd0);
    repeat (3) send_sample(16'sd7);
  endtask

  // a rising run of positive samples, then a falling run of negative ones
  task automatic test_order();
    send_sample(16'sd100);
    send_sample(16'sd200);
    send_sample(16'sd300);
    send_sample(16'sd400);
    send_sample(-16'sd100);
    send_sample(-16'sd200);
    send_sample(-16'sd300);
  endtask

  // mixed random stream: full range, narrow ties, ramps and near the rails
  task automatic test_random_stream(int count);
    int kind;
    sample_t x;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        x = sample_t'($urandom);
      end else if (kind < 6) begin
        x = sample_t'($urandom_range(0, 8) - 4);
      end else if (kind < 8) begin
        ramp_val = ramp_val + sample_t'($urandom_range(0, 64) - 24);
        x = ramp_val;
      end else if (kind == 8) begin
        x = sample_t'(32767 - $urandom_range(0, 7));
      end else begin
        x = sample_t'(-32768 + $urandom_range(0, 7));
      end
      send_sample(x);
    end
  endtask

  // hold-off once every expected median has arrived
  task automatic test_drain_pause();
    wait_drained();
    repeat ($urandom_range(3, 12)) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    clear_window();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_ties();
    test_order();
    test_random_stream(200);
    test_drain_pause();
    test_random_stream(200);

    // let the last medians come out
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_medians.size() != 0)
      report_fail($sformatf("%0d medians never arrived", expected_medians.size()));
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #500000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
